>>> rtl/pame_pkg.sv
`default_nettype none

package pame_pkg;

    localparam int DEF_NUM_POWERS = 32;
    localparam int DEF_COEF_WIDTH = 32;

    localparam int ACT_W       = 3;
    localparam int IN_COEF_W   = 32;
    localparam int IN_POW_W    = 5;
    localparam int OUT_COEF_W  = 32;
    localparam int POW_W       = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int OUT_PAD_W   = M_TDATA_W - OUT_COEF_W - POW_W;

    // multiplier digit: one COEF_WIDTH x DIG_W partial product per cycle unless stalled
    localparam int DIG_W     = 16;
    localparam int DIG_IDX_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A  = 3'd0,
        ACT_LOAD_B  = 3'd1,
        ACT_SUM     = 3'd2,
        ACT_PRODUCT = 3'd3,
        ACT_CLEAR   = 3'd4
    } pame_act_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_DRAIN = 5'b10000
    } pame_state_t;

    typedef struct packed {
        logic                 vld;
        logic                 flush;
        logic                 first;
        logic                 lastk;
        logic [DIG_IDX_W-1:0] dig;
        logic [POW_W-1:0]     pow;
    } pame_tag_t;

    typedef struct packed {
        logic             term;
        logic             flush;
        logic [POW_W-1:0] pow;
    } pame_res_t;

endpackage

`default_nettype wire

>>> rtl/pame_store.sv
`default_nettype none

module pame_store #(
    parameter int DEPTH  = pame_pkg::DEF_NUM_POWERS,
    parameter int WIDTH  = pame_pkg::DEF_COEF_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clr) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= vld_reg[raddr] ? mem_reg[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/pame_mac.sv
`default_nettype none

module pame_mac #(
    parameter int COEF_WIDTH = pame_pkg::DEF_COEF_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  stall,
    input  logic                  mode_sum,
    input  pame_pkg::pame_tag_t   t1,
    input  logic [COEF_WIDTH-1:0] a_q,
    input  logic [COEF_WIDTH-1:0] b_q,
    output logic [COEF_WIDTH-1:0] acc,
    output pame_pkg::pame_res_t   t3
);
    import pame_pkg::*;

    localparam int NDIG  = (COEF_WIDTH + DIG_W - 1) / DIG_W;
    localparam int BEXT_W = NDIG * DIG_W;
    localparam int MUL_W  = COEF_WIDTH + DIG_W;

    logic [BEXT_W-1:0]     b_ext;
    logic [DIG_W-1:0]      digit;
    logic [MUL_W-1:0]      mul_full;
    logic [COEF_WIDTH-1:0] prod_mul;
    logic [COEF_WIDTH-1:0] prod_next;
    logic [COEF_WIDTH-1:0] prod_reg;
    logic [COEF_WIDTH-1:0] acc_reg;
    logic [COEF_WIDTH-1:0] acc_next;
    pame_tag_t             t2_reg;
    pame_res_t             t3_reg;
    pame_res_t             t3_next;

    assign b_ext    = BEXT_W'(b_q);
    assign digit    = b_ext[DIG_W*t1.dig +: DIG_W];
    assign mul_full = MUL_W'(a_q) * MUL_W'(digit);
    assign prod_mul = COEF_WIDTH'(mul_full << (DIG_W*t1.dig));
    assign prod_next = mode_sum ? (a_q + b_q) : prod_mul;

    assign acc_next = (t2_reg.first ? '0 : acc_reg) + prod_reg;

    always_comb begin
        t3_next.term  = t2_reg.vld && t2_reg.lastk;
        t3_next.flush = t2_reg.flush;
        t3_next.pow   = t2_reg.pow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_reg <= '0;
            t3_reg <= '0;
        end else if (!stall) begin
            t2_reg <= t1;
            t3_reg <= t3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            prod_reg <= prod_next;
            if (t2_reg.vld) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc = acc_reg;
    assign t3  = t3_reg;

endmodule

`default_nettype wire

>>> rtl/pame_emit.sv
`default_nettype none

module pame_emit #(
    parameter int COEF_WIDTH = pame_pkg::DEF_COEF_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pame_pkg::pame_res_t            t3,
    input  logic [COEF_WIDTH-1:0]          acc,
    output logic                           stall,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pame_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);
    import pame_pkg::*;

    logic signed [COEF_WIDTH-1:0]    acc_s;
    logic signed [COEF_WIDTH+31:0]   acc_ext;
    logic [OUT_COEF_W-1:0]           new_coef;
    logic                            ev_term;
    logic                            need_push;
    logic                            out_free;
    logic                            push;
    logic [OUT_COEF_W-1:0]           push_coef;
    logic [POW_W-1:0]                push_pow;
    logic                            push_tv;
    logic                            push_last;

    logic                  pend_vld_reg, pend_vld_next;
    logic [OUT_COEF_W-1:0] pend_coef_reg;
    logic [POW_W-1:0]      pend_pow_reg;
    logic                  out_vld_reg, out_vld_next;
    logic [OUT_COEF_W-1:0] out_coef_reg;
    logic [POW_W-1:0]      out_pow_reg;
    logic                  out_tv_reg;
    logic                  out_last_reg;

    assign acc_s    = acc;
    assign acc_ext  = acc_s;
    assign new_coef = acc_ext[OUT_COEF_W-1:0];

    // last is known only once the next nonzero term or the sweep end shows up
    assign ev_term   = t3.term && (acc != '0);
    assign need_push = (ev_term && pend_vld_reg) || t3.flush;
    assign out_free  = !out_vld_reg || m_tready;
    assign stall     = need_push && !out_free;
    assign push      = need_push && out_free;

    always_comb begin
        push_coef     = pend_coef_reg;
        push_pow      = pend_pow_reg;
        push_tv       = pend_vld_reg;
        push_last     = t3.flush;
        pend_vld_next = pend_vld_reg;
        if (t3.flush) begin
            if (!pend_vld_reg) begin
                push_coef = '0;
                push_pow  = '0;
            end
            if (!stall) begin
                pend_vld_next = 1'b0;
            end
        end else if (ev_term && !stall) begin
            pend_vld_next = 1'b1;
        end
        if (push) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_term && !stall) begin
            pend_coef_reg <= new_coef;
            pend_pow_reg  <= t3.pow;
        end
        if (push) begin
            out_coef_reg <= push_coef;
            out_pow_reg  <= push_pow;
            out_tv_reg   <= push_tv;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_pow_reg, out_coef_reg};
    assign m_tuser  = out_tv_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/polynomial_add_multiply_engine_core.sv
`default_nettype none

// Channel  | Dir | Ports              | Transaction contents
// s_       | in  | tdata[39:0]        | coefficient[31:0], power[36:32]
//          |     | tuser[2:0]         | action[2:0]
// m_       | out | tdata[39:0]        | result_coeff[31:0], result_power[37:32]
//          |     | tuser[0], tlast    | term_valid, last
//
// Load: read-modify-write of the coefficient memory (read on accept, written in ST_LOAD).
// Clear and unused actions stay in idle. Sum: one term per output power.
// Product: NDIG = ceil(COEF_WIDTH/16); one COEF_WIDTH x 16 partial product per cycle
// unless stalled, memory ports read every cycle unless stalled.
// Reset clears the valid bits of both memories at once; no sweep.
// A held m_ output stalls the whole sweep when a result must be pushed; s_tready is high only when idle.

module polynomial_add_multiply_engine_core #(
    parameter int NUM_POWERS = pame_pkg::DEF_NUM_POWERS,
    parameter int COEF_WIDTH = pame_pkg::DEF_COEF_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pame_pkg::S_TDATA_W-1:0] s_tdata,   // coefficient, power, pad
    input  logic [pame_pkg::ACT_W-1:0]     s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pame_pkg::M_TDATA_W-1:0] m_tdata,   // result_coeff, result_power, pad
    output logic [0:0]                     m_tuser,   // term_valid
    output logic                           m_tlast
);
    import pame_pkg::*;

    localparam int PW   = $clog2(NUM_POWERS);
    localparam int KW   = $clog2(2*NUM_POWERS-1);
    localparam int NDIG = (COEF_WIDTH + DIG_W - 1) / DIG_W;

    pame_state_t state_reg, state_next;

    logic                  accept;
    logic [IN_POW_W-1:0]   in_pow;
    logic [PW-1:0]         in_idx;
    logic                  in_pow_ok;
    logic signed [COEF_WIDTH+31:0] cin_ext;
    logic [COEF_WIDTH-1:0] cin;

    logic [COEF_WIDTH-1:0] coef_reg;
    logic [PW-1:0]         pidx_reg;
    logic                  pw_ok_reg;
    logic                  sel_b_reg;
    logic                  mode_sum_reg, mode_sum_next;

    logic [KW-1:0]        k_reg, k_next, k_dec;
    logic [PW-1:0]        i_reg, i_next;
    logic [DIG_IDX_W-1:0] d_reg, d_next;
    logic [PW-1:0]        cur_lo, cur_hi, nxt_lo;
    logic                 d_last, i_last;

    pame_tag_t t0, t1_reg;
    pame_res_t t3;

    logic                  stall;
    logic                  done;
    logic                  clr;
    logic                  rd_en;
    logic [PW-1:0]         addr_a, addr_b;
    logic [COEF_WIDTH-1:0] a_q, b_q;
    logic [COEF_WIDTH-1:0] wdata;
    logic                  we_a, we_b;
    logic [COEF_WIDTH-1:0] acc;

    function automatic logic [PW-1:0] lo_idx(input logic [KW-1:0] k);
        if (k >= KW'(NUM_POWERS)) begin
            return PW'(k - KW'(NUM_POWERS-1));
        end
        return '0;
    endfunction

    function automatic logic [PW-1:0] hi_idx(input logic [KW-1:0] k);
        if (k < KW'(NUM_POWERS)) begin
            return PW'(k);
        end
        return PW'(NUM_POWERS-1);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_pow    = s_tdata[IN_COEF_W +: IN_POW_W];
    assign in_idx    = in_pow[PW-1:0];
    assign in_pow_ok = {1'b0, in_pow} < (IN_POW_W+1)'(NUM_POWERS);
    assign cin_ext   = $signed(s_tdata[IN_COEF_W-1:0]);
    assign cin       = cin_ext[COEF_WIDTH-1:0];
    assign clr       = accept && (s_tuser == ACT_CLEAR);

    // sequencer: output power k descending, i over the terms feeding it, digit d
    always_comb begin
        k_dec  = k_reg - KW'(1);
        cur_lo = mode_sum_reg ? PW'(k_reg) : lo_idx(k_reg);
        cur_hi = mode_sum_reg ? PW'(k_reg) : hi_idx(k_reg);
        nxt_lo = mode_sum_reg ? PW'(k_dec) : lo_idx(k_dec);
        d_last = mode_sum_reg || (d_reg == DIG_IDX_W'(NDIG-1));
        i_last = (i_reg == cur_hi);

        t0 = '0;
        if (state_reg == ST_ISSUE) begin
            t0.vld   = 1'b1;
            t0.first = (i_reg == cur_lo) && (d_reg == '0);
            t0.lastk = i_last && d_last;
            t0.dig   = d_reg;
            t0.pow   = POW_W'(k_reg);
        end else if (state_reg == ST_FLUSH) begin
            t0.flush = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        d_next        = d_reg;
        mode_sum_next = mode_sum_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority case (s_tuser)
                        ACT_LOAD_A, ACT_LOAD_B: begin
                            state_next = ST_LOAD;
                        end
                        ACT_SUM: begin
                            mode_sum_next = 1'b1;
                            k_next        = KW'(NUM_POWERS-1);
                            i_next        = PW'(NUM_POWERS-1);
                            d_next        = '0;
                            state_next    = ST_ISSUE;
                        end
                        ACT_PRODUCT: begin
                            mode_sum_next = 1'b0;
                            k_next        = KW'(2*NUM_POWERS-2);
                            i_next        = PW'(NUM_POWERS-1);
                            d_next        = '0;
                            state_next    = ST_ISSUE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                state_next = ST_IDLE;
            end
            ST_ISSUE: begin
                if (!stall) begin
                    if (!d_last) begin
                        d_next = d_reg + DIG_IDX_W'(1);
                    end else begin
                        d_next = '0;
                        if (!i_last) begin
                            i_next = i_reg + PW'(1);
                        end else if (k_reg == '0) begin
                            state_next = ST_FLUSH;
                        end else begin
                            k_next = k_dec;
                            i_next = nxt_lo;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!stall) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            t1_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (!stall) begin
                t1_reg <= t0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        i_reg        <= i_next;
        d_reg        <= d_next;
        mode_sum_reg <= mode_sum_next;
        if (accept) begin
            coef_reg  <= cin;
            pidx_reg  <= in_idx;
            pw_ok_reg <= in_pow_ok;
            sel_b_reg <= (s_tuser == ACT_LOAD_B);
        end
    end

    assign done   = t3.flush && !stall;
    assign rd_en  = !stall;
    assign addr_a = (state_reg == ST_IDLE) ? in_idx : i_reg;
    assign addr_b = (state_reg == ST_IDLE) ? in_idx :
                    (mode_sum_reg ? i_reg : PW'(k_reg - KW'(i_reg)));
    assign wdata  = (sel_b_reg ? b_q : a_q) + coef_reg;
    assign we_a   = (state_reg == ST_LOAD) && pw_ok_reg && !sel_b_reg;
    assign we_b   = (state_reg == ST_LOAD) && pw_ok_reg && sel_b_reg;

    pame_store #(
        .DEPTH (NUM_POWERS),
        .WIDTH (COEF_WIDTH)
    ) u_store_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr),
        .we      (we_a),
        .waddr   (pidx_reg),
        .wdata   (wdata),
        .re      (rd_en),
        .raddr   (addr_a),
        .rdata   (a_q)
    );

    pame_store #(
        .DEPTH (NUM_POWERS),
        .WIDTH (COEF_WIDTH)
    ) u_store_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr),
        .we      (we_b),
        .waddr   (pidx_reg),
        .wdata   (wdata),
        .re      (rd_en),
        .raddr   (addr_b),
        .rdata   (b_q)
    );

    pame_mac #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stall    (stall),
        .mode_sum (mode_sum_reg),
        .t1       (t1_reg),
        .a_q      (a_q),
        .b_q      (b_q),
        .acc      (acc),
        .t3       (t3)
    );

    pame_emit #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .t3       (t3),
        .acc      (acc),
        .stall    (stall),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_stall_needs_held_out: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> (m_tvalid && !m_tready))
        else $error("pipeline stalled without a held transaction");

    a_issue_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> ((i_reg >= cur_lo) && (i_reg <= cur_hi)))
        else $error("term index outside range for current power");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == ST_DRAIN) ##1 (state_reg == ST_IDLE))
        else $error("sweep end seen outside drain");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) || (state_reg == ST_LOAD))
            |-> (!t1_reg.vld && !t1_reg.flush && !t3.term && !t3.flush))
        else $error("sweep token in flight while idle");

endmodule

`default_nettype wire
